>>> sv/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Types and constants for the modem reply matcher.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int unsigned REPLY_DEPTH = 64;
  localparam int unsigned CountW      = 6;
  localparam int unsigned WinBytes    = 8;
  localparam int unsigned ErrLen      = 5;

  localparam int unsigned CountLimitInt = (REPLY_DEPTH - 1 > 63) ? 63 : REPLY_DEPTH - 1;
  localparam logic [CountW-1:0] CountLimit = CountW'(CountLimitInt);

  localparam logic [39:0] ErrorWord = 40'h45_52_52_4F_52;

  localparam logic [1:0] RegPattern = 2'd0;
  localparam logic [1:0] RegLength  = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;

  localparam logic [63:0] PatternReset = 64'd20299;
  localparam logic [3:0]  LengthReset  = 4'd2;
  localparam logic [7:0]  TimeoutReset = 8'd2;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdByte  = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StatTimeout = 2'd0,
    StatMatch   = 2'd1,
    StatError   = 2'd2,
    StatOther   = 2'd3
  } status_e;

  typedef struct packed {
    logic [CountW-1:0] reply_bytes;
    status_e           status;
    logic              busy_res;
    logic              finished;
  } result_t;

endpackage

>>> sv/modem_reply_matcher_with_timeout.sv
// ----------------------------------------------------------------------------
// modem_reply_matcher_with_timeout
// Matches modem reply bytes against an expected reply or ERROR, with timeout.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output register is empty or
// being taken; the state update and window compare sit between the input
// handshake and the single output register.
// Reset: asynchronous, active low; clears exchange state and loads the
// register defaults (pattern "OK", length 2, timeout 2 seconds).
module modem_reply_matcher_with_timeout
  import mrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] finished, [1] busy_res, [3:2] status,
                                      // [9:4] reply_bytes, [15:10] zero
);

  logic [63:0] pattern_q;
  logic [3:0]  length_q;
  logic [7:0]  timeout_q;

  logic [63:0]       window_q, window_d;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        elapsed_q, elapsed_d;
  logic              waiting_q, waiting_d;
  status_e           status_q, status_d;
  logic              done;

  logic              out_valid_q;
  result_t           out_q;

  logic              accept;
  logic [63:0]       win_shift;
  logic [CountW-1:0] count_inc;
  logic [7:0]        elapsed_inc;
  logic [3:0]        len_eff;
  logic [WinBytes-1:0] byte_eq;
  logic              pat_hit, err_hit;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PatternReset;
      length_q  <= LengthReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPattern: pattern_q <= cfg_wdata_i;
        RegLength:  length_q  <= cfg_wdata_i[3:0];
        RegTimeout: timeout_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign win_shift   = {window_q[55:0], s_axis_tdata};
  assign count_inc   = (count_q < CountLimit) ? count_q + 1'b1 : count_q;
  assign elapsed_inc = (elapsed_q != 8'hFF) ? elapsed_q + 1'b1 : elapsed_q;
  assign len_eff     = (length_q > 4'd8) ? 4'd8 : length_q;

  always_comb begin
    for (int i = 0; i < WinBytes; i++) begin
      byte_eq[i] = (win_shift[8*i +: 8] == pattern_q[8*i +: 8]) || (4'(i) >= len_eff);
    end
  end

  assign pat_hit = (&byte_eq) && ({2'b00, count_inc} >= {4'b0000, len_eff});
  assign err_hit = (win_shift[39:0] == ErrorWord) && (count_inc >= CountW'(ErrLen));

  always_comb begin
    window_d  = window_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    waiting_d = waiting_q;
    status_d  = status_q;
    done      = 1'b0;
    case (cmd_e'(s_axis_tuser))
      CmdStart: begin
        window_d  = '0;
        count_d   = '0;
        elapsed_d = '0;
        status_d  = StatTimeout;
        waiting_d = 1'b1;
        if (timeout_q == 8'd0) begin
          waiting_d = 1'b0;
          done      = 1'b1;
        end
      end
      CmdByte: begin
        if (waiting_q) begin
          window_d = win_shift;
          count_d  = count_inc;
          if (pat_hit) begin
            status_d  = StatMatch;
            waiting_d = 1'b0;
            done      = 1'b1;
          end else if (err_hit) begin
            status_d  = StatError;
            waiting_d = 1'b0;
            done      = 1'b1;
          end
        end
      end
      CmdTick: begin
        if (waiting_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            status_d  = (count_q != '0) ? StatOther : StatTimeout;
            waiting_d = 1'b0;
            done      = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      count_q     <= '0;
      elapsed_q   <= '0;
      waiting_q   <= 1'b0;
      status_q    <= StatTimeout;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        window_q  <= window_d;
        count_q   <= count_d;
        elapsed_q <= elapsed_d;
        waiting_q <= waiting_d;
        status_q  <= status_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.finished    <= done;
      out_q.busy_res    <= waiting_d;
      out_q.status      <= status_d;
      out_q.reply_bytes <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_q};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the modem reply matcher against a cycle-free predictor of its state:
// directed exchanges first, then random well-formed and broken exchanges under
// several register settings, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import mrm_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  // Tracks the exchange state and queues the result each transaction causes.
  class exchange_scoreboard;
    logic [63:0] pattern;
    logic [3:0]  plen;
    logic [7:0]  tmo;
    logic [63:0] window;
    logic [5:0]  count;
    logic [7:0]  secs;
    bit          open;
    status_e     stat;
    result_t     expected_replies[$];
    int          errors;
    int          outcomes[4];
    int          results_seen;

    function new();
      pattern = PatternReset;
      plen    = LengthReset;
      tmo     = TimeoutReset;
      window  = '0;
      count   = '0;
      secs    = '0;
      open    = 1'b0;
      stat    = StatTimeout;
      errors  = 0;
      results_seen = 0;
      foreach (outcomes[i]) outcomes[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        RegPattern: pattern = data;
        RegLength:  plen    = data[3:0];
        RegTimeout: tmo     = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function bit window_hit(logic [63:0] pat, int len);
      logic [63:0] mask;
      if (len > 8) len = 8;
      if (int'(count) < len) return 1'b0;
      if (len == 0) return 1'b1;
      mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
      return ((window ^ pat) & mask) == '0;
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] b);
      result_t r;
      bit      done;
      done = 1'b0;
      case (cmd)
        CmdStart: begin
          window = '0;
          count  = '0;
          secs   = '0;
          stat   = StatTimeout;
          open   = 1'b1;
          if (tmo == 0) begin
            open = 1'b0;
            done = 1'b1;
          end
        end
        CmdByte: if (open) begin
          window = {window[55:0], b};
          if (count < CountLimit) count++;
          if (window_hit(pattern, int'(plen))) begin
            stat = StatMatch;
            open = 1'b0;
            done = 1'b1;
          end else if (window_hit({24'd0, ErrorWord}, ErrLen)) begin
            stat = StatError;
            open = 1'b0;
            done = 1'b1;
          end
        end
        CmdTick: if (open) begin
          if (secs < 8'd255) secs++;
          if (secs >= tmo) begin
            stat = (count != 0) ? StatOther : StatTimeout;
            open = 1'b0;
            done = 1'b1;
          end
        end
        default: ;
      endcase
      r.finished    = done;
      r.busy_res    = open;
      r.status      = stat;
      r.reply_bytes = count;
      expected_replies.push_back(r);
    endfunction

    function void check_result(logic [15:0] d);
      result_t got;
      result_t want;
      got = result_t'(d[9:0]);
      if (expected_replies.size() == 0) begin
        $error("result transaction %h with no expectation pending", d);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      results_seen++;
      if (want.finished) outcomes[int'(want.status)]++;
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, got %0d", want.finished, got.finished);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.reply_bytes !== want.reply_bytes) begin
        $error("reply_bytes: expected %0d, got %0d", want.reply_bytes, got.reply_bytes);
        errors++;
      end
      if (d[15:10] !== 6'd0) begin
        $error("pad: expected 0, got %h", d[15:10]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] finished, [1] busy_res, [3:2] status,
                               // [9:4] reply_bytes, [15:10] zero

  exchange_scoreboard sb = new();
  bit          idle_on;
  int          items_sent;
  int unsigned cycle_cnt;

  modem_reply_matcher_with_timeout dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  always @(negedge clk_i) begin
    m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 35) : 1'b1;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic [1:0] cmd, logic [7:0] b);
    while (idle_on && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic run_exchange();
    int kind;
    int eff;
    int n;
    kind = $urandom_range(0, 9);
    eff  = (sb.plen > 8) ? 8 : int'(sb.plen);
    send_item(CmdStart, 8'($urandom));
    case (kind)
      0, 1, 2: begin
        n = $urandom_range(0, 3);
        repeat (n) send_item(CmdByte, 8'($urandom));
        if ($urandom_range(0, 3) == 0) send_item(CmdTick, 8'($urandom));
        for (int i = eff - 1; i >= 0; i--) send_item(CmdByte, sb.pattern[8*i +: 8]);
      end
      3, 4: begin
        n = $urandom_range(0, 3);
        repeat (n) send_item(CmdByte, 8'($urandom));
        for (int i = ErrLen - 1; i >= 0; i--) send_item(CmdByte, ErrorWord[8*i +: 8]);
      end
      5, 6: begin
        n = $urandom_range(0, 2);
        repeat (n) send_item(CmdByte, 8'($urandom));
        n = (sb.tmo > 12) ? 3 : int'(sb.tmo) + $urandom_range(0, 1);
        repeat (n) send_item(CmdTick, 8'($urandom));
      end
      7: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
      8: begin
        for (int i = eff - 1; i >= 1; i--) send_item(CmdByte, sb.pattern[8*i +: 8]);
        send_item(CmdByte, 8'($urandom));
        send_item(CmdTick, 8'($urandom));
      end
      default: begin
        n = $urandom_range(1, 70);
        repeat (n) send_item(CmdByte, 8'($urandom));
      end
    endcase
    if ($urandom_range(0, 4) == 0) send_item(2'($urandom_range(1, 3)), 8'($urandom));
  endtask

  task automatic run_phase(logic [63:0] pat, logic [3:0] len, logic [7:0] tmo, int quota);
    int first;
    drain();
    write_reg(RegPattern, pat);
    write_reg(RegLength, {60'd0, len});
    write_reg(RegTimeout, {56'd0, tmo});
    cfg_we_i <= 1'b0;
    first = items_sent;
    while (items_sent - first < quota) run_exchange();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegPattern;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdStart;
    m_axis_tready = 1'b0;
    idle_on       = 1'b1;
    items_sent    = 0;
    cycle_cnt     = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle bytes, ticks and the unused command
    send_item(CmdByte, 8'hFF);
    send_item(CmdTick, 8'h00);
    send_item(CmdUnused, 8'hA5);
    // default pattern "OK"
    send_item(CmdStart, 8'h00);
    send_item(CmdByte, 8'h4F);
    send_item(CmdByte, 8'h4B);
    // error reply
    send_item(CmdStart, 8'h5A);
    for (int i = ErrLen - 1; i >= 0; i--) send_item(CmdByte, ErrorWord[8*i +: 8]);
    // silent timeout, then timeout after a byte
    send_item(CmdStart, 8'h00);
    send_item(CmdTick, 8'hFF);
    send_item(CmdTick, 8'h00);
    send_item(CmdStart, 8'h00);
    send_item(CmdByte, 8'h00);
    send_item(CmdTick, 8'h00);
    send_item(CmdTick, 8'h00);
    // restart mid-exchange: bytes before the restart must not count
    send_item(CmdStart, 8'h00);
    send_item(CmdByte, 8'h4F);
    send_item(CmdStart, 8'h00);
    send_item(CmdByte, 8'h4B);

    run_phase({24'd0, ErrorWord}, 4'd5, 8'd3, 40);
    run_phase({$urandom, $urandom}, 4'd0, 8'd3, 40);
    run_phase({$urandom, $urandom}, 4'd15, 8'd4, 50);
    run_phase(64'd0, 4'd8, 8'd1, 40);
    idle_on = 1'b0;
    run_phase({$urandom, $urandom}, 4'($urandom_range(1, 8)), 8'($urandom_range(1, 6)), 120);
    idle_on = 1'b1;
    // saturating byte count and the longest timeout
    run_phase('1, 4'd8, 8'd255, 0);
    send_item(CmdStart, 8'h00);
    repeat (70) send_item(CmdByte, 8'($urandom_range(0, 254)));
    repeat (255) send_item(CmdTick, 8'($urandom));
    run_phase({$urandom, $urandom}, 4'd2, 8'd0, 30);
    while (items_sent < 950) begin
      run_phase({$urandom, $urandom}, 4'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), 80);
    end
    drain();
    repeat (5) @(posedge clk_i);

    $display("%0d input transactions, %0d results checked", items_sent, sb.results_seen);
    $display("exchanges ended: %0d matched, %0d error, %0d other reply, %0d silent timeout",
             sb.outcomes[StatMatch], sb.outcomes[StatError], sb.outcomes[StatOther],
             sb.outcomes[StatTimeout]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
